### rtl/pbrle_pkg.sv
// ----------------------------------------------------------------------------
// Pixel PackBits RLE decoder package
// Shared types and constants for the decoder, its register block and its core.
// ----------------------------------------------------------------------------
package pbrle_pkg;

  localparam int TotalWidth = 25;
  localparam int BppWidth   = 3;
  localparam int AddrWidth  = 3;
  localparam int DataWidth  = 32;

  localparam logic [7:0] CtrlNop = 8'h80;

  typedef enum logic [AddrWidth-3:0] {
    REG_BPP   = 1'b0,
    REG_TOTAL = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_CTRL    = 2'd0,
    PH_LITERAL = 2'd1,
    PH_REPEAT  = 2'd2,
    PH_HALT    = 2'd3
  } phase_e;

  typedef struct packed {
    logic [BppWidth-1:0]   bytes_per_pixel;
    logic [TotalWidth-1:0] total_pixels;
  } cfg_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        done_res;
    logic        failed;
  } res_t;

endpackage

### rtl/pbrle_in_if.sv
// ----------------------------------------------------------------------------
// Compressed byte channel
// Valid/ready channel that carries one compressed stream byte per transfer.
// ----------------------------------------------------------------------------
interface pbrle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink (input valid, input in_byte, input stream_end, output ready);
endinterface

### rtl/pbrle_out_if.sv
// ----------------------------------------------------------------------------
// Decoded pixel channel
// Valid/ready channel that carries one decoded pixel or end-of-stream status.
// ----------------------------------------------------------------------------
interface pbrle_out_if;
  logic        valid;
  logic        ready;
  logic        pixel_valid;
  logic [31:0] pixel_value;
  logic [7:0]  repeat_count;
  logic        done_res;
  logic        failed;

  modport source (output valid, output pixel_valid, output pixel_value,
                  output repeat_count, output done_res, output failed, input ready);
  modport sink (input valid, input pixel_valid, input pixel_value,
                input repeat_count, input done_res, input failed, output ready);
endinterface

### rtl/pbrle_cfg.sv
// ----------------------------------------------------------------------------
// Pixel PackBits RLE decoder registers
// APB-style register block holding bytes per pixel and the image pixel total.
// ----------------------------------------------------------------------------
module pbrle_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pbrle_pkg::AddrWidth-1:0] paddr,
  input  logic [pbrle_pkg::DataWidth-1:0] pwdata,
  output logic [pbrle_pkg::DataWidth-1:0] prdata,
  output logic                            pready,
  output pbrle_pkg::cfg_t                 cfg_o
);
  import pbrle_pkg::*;

  logic                  wr_en;
  reg_idx_e              reg_sel;
  logic [BppWidth-1:0]   bpp_q;
  logic [TotalWidth-1:0] total_q;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = reg_idx_e'(paddr[AddrWidth-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q   <= BppWidth'(1);
      total_q <= TotalWidth'(1);
    end else if (wr_en) begin
      case (reg_sel)
        REG_BPP:   bpp_q   <= pwdata[BppWidth-1:0];
        REG_TOTAL: total_q <= pwdata[TotalWidth-1:0];
        default:   bpp_q   <= bpp_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_BPP:   prdata = DataWidth'(bpp_q);
      REG_TOTAL: prdata = DataWidth'(total_q);
      default:   prdata = '0;
    endcase
  end

  assign cfg_o.bytes_per_pixel = bpp_q;
  assign cfg_o.total_pixels    = total_q;

endmodule

### rtl/pbrle_core.sv
// ----------------------------------------------------------------------------
// Pixel PackBits RLE decoder core
// Stream state and the combinational step logic that decodes one byte per step.
// ----------------------------------------------------------------------------
module pbrle_core #(
  parameter int PIXEL_COUNT_BITS = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      in_byte_i,
  input  logic            stream_end_i,
  input  pbrle_pkg::cfg_t cfg_i,
  output logic            has_res_o,
  output pbrle_pkg::res_t res_o
);
  import pbrle_pkg::*;

  localparam int CW = PIXEL_COUNT_BITS + 1;
  localparam int TW = (CW > TotalWidth) ? CW : TotalWidth;

  phase_e      phase_q, phase_d;
  logic [7:0]  run_left_q, run_left_d;
  logic [7:0]  run_rep_q, run_rep_d;
  logic [1:0]  idx_q, idx_d;
  logic [31:0] buf_q, buf_d;
  logic [CW-1:0] done_cnt_q, done_cnt_d;
  logic        err_q, err_d;

  logic [TW-1:0] cap_w, total_w;
  logic [CW-1:0] eff_total;
  logic [2:0]    eff_bpp;
  logic [7:0]    cnt;
  logic [CW:0]   sum;
  logic [31:0]   merged;
  logic          has_pix;
  logic [31:0]   pix;
  logic [7:0]    rep;

  assign cap_w     = TW'(1) << PIXEL_COUNT_BITS;
  assign total_w   = TW'(cfg_i.total_pixels);
  assign eff_total = (total_w > cap_w) ? cap_w[CW-1:0] : total_w[CW-1:0];
  assign eff_bpp   = (cfg_i.bytes_per_pixel == 3'd0) ? 3'd1 :
                     (cfg_i.bytes_per_pixel > 3'd4) ? 3'd4 : cfg_i.bytes_per_pixel;
  assign cnt       = in_byte_i[7] ? (~in_byte_i + 8'd2) : (in_byte_i + 8'd1);
  assign sum       = {1'b0, done_cnt_q} + (CW+1)'(cnt);
  assign merged    = buf_q | (32'(in_byte_i) << {idx_q, 3'b000});

  always_comb begin
    phase_d    = phase_q;
    run_left_d = run_left_q;
    run_rep_d  = run_rep_q;
    idx_d      = idx_q;
    buf_d      = buf_q;
    done_cnt_d = done_cnt_q;
    err_d      = err_q;
    has_pix    = 1'b0;
    pix        = '0;
    rep        = '0;
    case (phase_q)
      PH_CTRL: begin
        if (done_cnt_q < eff_total && in_byte_i != CtrlNop) begin
          if (sum > {1'b0, eff_total}) begin
            err_d   = 1'b1;
            phase_d = PH_HALT;
          end else begin
            done_cnt_d = sum[CW-1:0];
            idx_d      = '0;
            buf_d      = '0;
            if (!in_byte_i[7]) begin
              run_left_d = cnt;
              run_rep_d  = 8'd1;
              phase_d    = PH_LITERAL;
            end else begin
              run_left_d = 8'd1;
              run_rep_d  = cnt;
              phase_d    = PH_REPEAT;
            end
          end
        end
      end
      PH_LITERAL, PH_REPEAT: begin
        if ({1'b0, idx_q} + 3'd1 >= eff_bpp) begin
          has_pix    = 1'b1;
          pix        = merged;
          rep        = (phase_q == PH_REPEAT) ? run_rep_q : 8'd1;
          buf_d      = '0;
          idx_d      = '0;
          run_left_d = run_left_q - 8'd1;
          if (run_left_d == 8'd0) begin
            phase_d   = PH_CTRL;
            run_rep_d = 8'd1;
          end
        end else begin
          idx_d = idx_q + 2'd1;
          buf_d = merged;
        end
      end
      default: begin
        phase_d = PH_HALT;
      end
    endcase

    res_o.pixel_valid  = has_pix;
    res_o.pixel_value  = pix;
    res_o.repeat_count = rep;
    res_o.done_res     = stream_end_i;
    res_o.failed       = stream_end_i &&
                         (err_d || phase_d != PH_CTRL || done_cnt_d != eff_total);
    has_res_o          = has_pix || stream_end_i;

    if (stream_end_i) begin
      phase_d    = PH_CTRL;
      run_left_d = '0;
      run_rep_d  = 8'd1;
      idx_d      = '0;
      buf_d      = '0;
      done_cnt_d = '0;
      err_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_CTRL;
      run_left_q <= '0;
      run_rep_q  <= 8'd1;
      idx_q      <= '0;
      buf_q      <= '0;
      done_cnt_q <= '0;
      err_q      <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      run_left_q <= run_left_d;
      run_rep_q  <= run_rep_d;
      idx_q      <= idx_d;
      buf_q      <= buf_d;
      done_cnt_q <= done_cnt_d;
      err_q      <= err_d;
    end
  end

endmodule

### rtl/pixel_packbits_rle_decoder.sv
// ----------------------------------------------------------------------------
// Pixel PackBits RLE decoder
// Decodes a pixel-granular PackBits byte stream into pixels with repeat counts.
// ----------------------------------------------------------------------------
// Compressed bytes enter on in_i, one byte per transfer; stream_end marks the
// last byte of a stream. Each byte that completes a pixel yields one result on
// out_o with the pixel and its repeat count; the final byte always yields a
// result with done_res set and failed reporting a short or malformed stream.
// Control bytes and incomplete pixel bytes yield no result.
// A byte is registered at the input and decoded from that register, and its
// result is registered at the output. One byte per cycle is sustained while
// the receiver takes results; the stream state updates once per byte.
// When the receiver stalls, the result register holds and the input register
// fills; further input is refused until the result is taken.
// Reset empties both registers, returns the stream state to expecting a
// control byte, and sets bytes per pixel and the pixel total to one.
// Registers are written over APB at addresses 0 and 4; the user must do so only while idle (not enforced).
// ----------------------------------------------------------------------------
module pixel_packbits_rle_decoder #(
  parameter int PIXEL_COUNT_BITS = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  pbrle_in_if.sink                        in_i,
  pbrle_out_if.source                     out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pbrle_pkg::AddrWidth-1:0] paddr,
  input  logic [pbrle_pkg::DataWidth-1:0] pwdata,
  output logic [pbrle_pkg::DataWidth-1:0] prdata,
  output logic                            pready
);
  import pbrle_pkg::*;

  cfg_t       cfg;
  logic       inq_valid_q;
  logic [7:0] inq_byte_q;
  logic       inq_end_q;
  logic       advance;
  logic       step;
  logic       has_res;
  res_t       res;
  logic       res_valid_q, res_valid_d;
  res_t       res_q;

  pbrle_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign advance  = !res_valid_q || out_o.ready;
  assign step     = inq_valid_q && advance;
  assign in_i.ready = !inq_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      inq_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      inq_byte_q <= in_i.in_byte;
      inq_end_q  <= in_i.stream_end;
    end
  end

  pbrle_core #(
    .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .in_byte_i    (inq_byte_q),
    .stream_end_i (inq_end_q),
    .cfg_i        (cfg),
    .has_res_o    (has_res),
    .res_o        (res)
  );

  always_comb begin
    if (step && has_res) begin
      res_valid_d = 1'b1;
    end else if (out_o.ready) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && has_res) begin
      res_q <= res;
    end
  end

  assign out_o.valid        = res_valid_q;
  assign out_o.pixel_valid  = res_q.pixel_valid;
  assign out_o.pixel_value  = res_q.pixel_value;
  assign out_o.repeat_count = res_q.repeat_count;
  assign out_o.done_res     = res_q.done_res;
  assign out_o.failed       = res_q.failed;

  a_res_has_content: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_q.pixel_valid || res_q.done_res))
    else $error("Result carries neither a pixel nor end-of-stream status.");

  a_pixel_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.pixel_valid) |-> (res_q.repeat_count != 8'd0))
    else $error("Decoded pixel has a zero repeat count.");

  a_failed_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.failed) |-> res_q.done_res)
    else $error("Failure reported on a result that does not end the stream.");

  a_stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !out_o.ready) |=> (res_valid_q && $stable(res_q) && !$past(step)))
    else $error("Result register changed or a byte was decoded during a stall.");

endmodule
